### hw/rtl/ftlb_pkg.sv
package ftlb_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam int PAGE_BITS = 12;
   localparam int SUPER_BITS = 22;
   localparam int PAGE_W = 32 - PAGE_BITS;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_REFILL = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [31:0] vaddr;
      logic [31:0] phys_base;
      logic page_level;
      logic [2:0] access_kind;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [31:0] phys_addr;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [31:0] base;
      logic level;
      logic [2:0] kind;
   } entry_data_type;

   typedef struct packed {
      logic valid;
      entry_data_type data;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic [31:0] vaddr;
      logic [2:0] kind;
      logic hit;
      logic [31:0] paddr;
   } probe_type;

   typedef struct packed {
      logic shift;
      logic write;
      logic flush;
      logic [IDX_W-1:0] slot;
      entry_data_type data;
   } cmd_type;

   function automatic logic [PAGE_W-1:0] page_of(input logic [31:0] va, input logic level);
      logic [PAGE_W-1:0] result;
      if (level) begin
         result = PAGE_W'(va[31:SUPER_BITS]);
      end else begin
         result = va[31:PAGE_BITS];
      end
      return result;
   endfunction

   function automatic logic [31:0] offset_of(input logic [31:0] va, input logic level);
      logic [31:0] result;
      if (level) begin
         result = {{(32 - SUPER_BITS){1'b0}}, va[SUPER_BITS-1:0]};
      end else begin
         result = {{(32 - PAGE_BITS){1'b0}}, va[PAGE_BITS-1:0]};
      end
      return result;
   endfunction

endpackage

### hw/rtl/fifo_tlb_with_superpages.sv
// A lookup travels down the row of entry cells, one cell per cycle; busy stays high until its
// result appears, and the next request is taken in the cycle after the result.
// Refill, flush and no-operation requests do not set busy; their result appears in the
// next cycle and a new request may be taken in every cycle.
// Reset clears all valid bits, the fill count and the busy flag; no clearing pass is needed.
// Results are shown for one cycle under rsp_strobe and the receiver cannot stall them.
module fifo_tlb_with_superpages (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input ftlb_pkg::req_type req,
   output logic rsp_strobe,
   output ftlb_pkg::rsp_type rsp
);

   logic accept;
   logic busy_ff;
   logic busy_in;
   logic other_ff;
   logic other_in;
   logic full;
   logic [ftlb_pkg::CNT_W-1:0] fill_count_ff;
   logic [ftlb_pkg::CNT_W-1:0] fill_count_in;
   ftlb_pkg::cmd_type cmd;
   ftlb_pkg::probe_type probe_head;
   ftlb_pkg::probe_type probe_chain [ftlb_pkg::ENTRIES];
   ftlb_pkg::entry_type entry_chain [ftlb_pkg::ENTRIES];
   ftlb_pkg::probe_type probe_last;

   assign accept = start && !busy_ff;
   assign busy = busy_ff;
   assign full = (fill_count_ff == ftlb_pkg::CNT_W'(ftlb_pkg::ENTRIES));
   assign probe_last = probe_chain[ftlb_pkg::ENTRIES-1];

   always_comb begin
      cmd.shift = accept && (req.opcode == ftlb_pkg::OP_REFILL) && full;
      cmd.write = accept && (req.opcode == ftlb_pkg::OP_REFILL);
      cmd.flush = accept && (req.opcode == ftlb_pkg::OP_FLUSH);
      if (full) begin
         cmd.slot = ftlb_pkg::IDX_W'(ftlb_pkg::ENTRIES - 1);
      end else begin
         cmd.slot = fill_count_ff[ftlb_pkg::IDX_W-1:0];
      end
      cmd.data.page = ftlb_pkg::page_of(req.vaddr, req.page_level);
      cmd.data.base = req.phys_base;
      cmd.data.level = req.page_level;
      cmd.data.kind = req.access_kind;
   end

   always_comb begin
      probe_head.valid = accept && (req.opcode == ftlb_pkg::OP_LOOKUP);
      probe_head.vaddr = req.vaddr;
      probe_head.kind = req.access_kind;
      probe_head.hit = 1'b0;
      probe_head.paddr = '0;
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (cmd.write && !full) begin
         fill_count_in = fill_count_ff + ftlb_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (probe_head.valid) begin
         busy_in = 1'b1;
      end else if (probe_last.valid) begin
         busy_in = 1'b0;
      end
   end

   assign other_in = accept && (req.opcode != ftlb_pkg::OP_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         other_ff <= 1'b0;
         fill_count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         other_ff <= other_in;
         fill_count_ff <= fill_count_in;
      end
   end

   for (genvar i = 0; i < ftlb_pkg::ENTRIES; i++) begin : g_cell
      ftlb_pkg::entry_type next_entry;
      ftlb_pkg::probe_type prev_probe;

      if (i == ftlb_pkg::ENTRIES - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_body
         assign next_entry = entry_chain[i+1];
      end

      if (i == 0) begin : g_first
         assign prev_probe = probe_head;
      end else begin : g_rest
         assign prev_probe = probe_chain[i-1];
      end

      ftlb_cell u_cell (
         .clock(clock),
         .reset(reset),
         .cell_index(ftlb_pkg::IDX_W'(i)),
         .cmd(cmd),
         .entry_next(next_entry),
         .entry_out(entry_chain[i]),
         .probe_prev(prev_probe),
         .probe_out(probe_chain[i])
      );
   end

   assign rsp_strobe = probe_last.valid || other_ff;

   always_comb begin
      rsp = '0;
      if (probe_last.valid) begin
         rsp.hit = probe_last.hit;
         rsp.phys_addr = probe_last.paddr;
      end
   end

endmodule

### hw/rtl/ftlb_cell.sv
module ftlb_cell (
   input logic clock,
   input logic reset,
   input logic [ftlb_pkg::IDX_W-1:0] cell_index,
   input ftlb_pkg::cmd_type cmd,
   input ftlb_pkg::entry_type entry_next,
   output ftlb_pkg::entry_type entry_out,
   input ftlb_pkg::probe_type probe_prev,
   output ftlb_pkg::probe_type probe_out
);

   logic valid_ff;
   logic valid_in;
   ftlb_pkg::entry_data_type data_ff;
   ftlb_pkg::entry_data_type data_in;
   ftlb_pkg::probe_type probe_ff;
   ftlb_pkg::probe_type probe_in;
   logic selected;
   logic match;

   assign selected = cmd.write && (cmd.slot == cell_index);

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (cmd.flush) begin
         valid_in = 1'b0;
      end else if (selected) begin
         valid_in = 1'b1;
         data_in = cmd.data;
      end else if (cmd.shift) begin
         valid_in = entry_next.valid;
         data_in = entry_next.data;
      end
   end

   assign match = valid_ff
      && (data_ff.page == ftlb_pkg::page_of(probe_prev.vaddr, data_ff.level))
      && (data_ff.kind == probe_prev.kind);

   always_comb begin
      probe_in = probe_prev;
      if (probe_prev.valid && !probe_prev.hit && match) begin
         probe_in.hit = 1'b1;
         probe_in.paddr = data_ff.base | ftlb_pkg::offset_of(probe_prev.vaddr, data_ff.level);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.data = data_ff;
   assign probe_out = probe_ff;

endmodule

### dv/fifo_tlb_with_superpages_tb.sv
module fifo_tlb_with_superpages_tb;
   import ftlb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = ENTRIES + 8;
   localparam int HISTORY_DEPTH = 96;

   typedef struct packed {
      logic [31:0] vaddr;
      logic level;
      logic [2:0] kind;
   } mapping_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req;
   logic rsp_strobe;
   rsp_type rsp;

   logic slot_valid [ENTRIES];
   logic [PAGE_W-1:0] slot_vpn [ENTRIES];
   logic [31:0] slot_base [ENTRIES];
   logic slot_super [ENTRIES];
   logic [2:0] slot_kind [ENTRIES];
   int slots_used;

   rsp_type expected_rsp_q[$];
   mapping_type mapping_history[$];
   int error_count;
   int cycle_count;
   int sender_idle_pct;

   fifo_tlb_with_superpages u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_strobe(rsp_strobe),
      .rsp(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fifo_tlb_with_superpages_tb failed");
         $finish;
      end
   end

   function automatic rsp_type translate_and_update(req_type r);
      rsp_type res;
      logic [PAGE_W-1:0] vpn;
      int i;
      res = '0;
      case (r.opcode)
         OP_LOOKUP: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && !res.hit) begin
                  if (slot_super[i]) begin
                     vpn = PAGE_W'(r.vaddr[31:SUPER_BITS]);
                  end else begin
                     vpn = r.vaddr[31:PAGE_BITS];
                  end
                  if (slot_vpn[i] == vpn && slot_kind[i] == r.access_kind) begin
                     res.hit = 1'b1;
                     if (slot_super[i]) begin
                        res.phys_addr = slot_base[i] | (r.vaddr & ((32'd1 << SUPER_BITS) - 1));
                     end else begin
                        res.phys_addr = slot_base[i] | (r.vaddr & ((32'd1 << PAGE_BITS) - 1));
                     end
                  end
               end
            end
         end
         OP_REFILL: begin
            if (slots_used >= ENTRIES) begin
               for (i = 0; i < ENTRIES - 1; i++) begin
                  slot_valid[i] = slot_valid[i + 1];
                  slot_vpn[i] = slot_vpn[i + 1];
                  slot_base[i] = slot_base[i + 1];
                  slot_super[i] = slot_super[i + 1];
                  slot_kind[i] = slot_kind[i + 1];
               end
               slot_valid[ENTRIES - 1] = 1'b0;
               slots_used = ENTRIES - 1;
            end
            slot_valid[slots_used] = 1'b1;
            if (r.page_level) begin
               slot_vpn[slots_used] = PAGE_W'(r.vaddr[31:SUPER_BITS]);
            end else begin
               slot_vpn[slots_used] = r.vaddr[31:PAGE_BITS];
            end
            slot_base[slots_used] = r.phys_base;
            slot_super[slots_used] = r.page_level;
            slot_kind[slots_used] = r.access_kind;
            slots_used++;
         end
         OP_FLUSH: begin
            for (i = 0; i < ENTRIES; i++) begin
               slot_valid[i] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      int i;
      if (reset) begin
         expected_rsp_q.delete();
         for (i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_vpn[i] = '0;
            slot_base[i] = '0;
            slot_super[i] = 1'b0;
            slot_kind[i] = '0;
         end
         slots_used = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result with no request outstanding: hit %0d phys_addr %h",
                      rsp.hit, rsp.phys_addr);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
                  error_count++;
               end
               if (rsp.phys_addr !== want.phys_addr) begin
                  $error("phys_addr: expected %h, actual %h", want.phys_addr, rsp.phys_addr);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_rsp_q.push_back(translate_and_update(req));
         end
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [31:0] va, logic [31:0] base,
                                        logic level, logic [2:0] kind);
      req_type r;
      r.opcode = op;
      r.vaddr = va;
      r.phys_base = base;
      r.page_level = level;
      r.access_kind = kind;
      return r;
   endfunction

   task automatic send_request(req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         req <= req_type'($bits(req_type)'({$urandom(), $urandom(), $urandom()}));
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      if (r.opcode == OP_REFILL) begin
         mapping_history.push_back({r.vaddr, r.page_level, r.access_kind});
         if (mapping_history.size() > HISTORY_DEPTH) begin
            void'(mapping_history.pop_front());
         end
      end
   endtask

   task automatic test_basic_hits();
      send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0, 1'b0, 3'd0));
      send_request(make_req(OP_REFILL, 32'hFFFF_FFFF, 32'hFFFF_F000, 1'b0, 3'd7));
      send_request(make_req(OP_LOOKUP, 32'hFFFF_FABC, 32'h0, 1'b0, 3'd7));
      send_request(make_req(OP_LOOKUP, 32'hFFFF_FABC, 32'h0, 1'b1, 3'd6));
      send_request(make_req(OP_REFILL, 32'h0000_0000, 32'h0000_0000, 1'b1, 3'd0));
      send_request(make_req(OP_LOOKUP, 32'h003F_FFFF, 32'hFFFF_FFFF, 1'b0, 3'd0));
      send_request(make_req(OP_LOOKUP, 32'h0040_0000, 32'h0, 1'b0, 3'd0));
   endtask

   task automatic test_overlap_order();
      send_request(make_req(OP_REFILL, 32'h1234_5678, 32'hAAAA_A000, 1'b0, 3'd3));
      send_request(make_req(OP_REFILL, 32'h1234_5000, 32'h5555_5000, 1'b0, 3'd3));
      send_request(make_req(OP_LOOKUP, 32'h1234_5FFF, 32'h0, 1'b0, 3'd3));
      send_request(make_req(OP_REFILL, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 3'd5));
      send_request(make_req(OP_LOOKUP, 32'h8012_3456, 32'h0, 1'b0, 3'd5));
      send_request(make_req(OP_REFILL, 32'h8010_0000, 32'h0100_0000, 1'b0, 3'd5));
      send_request(make_req(OP_LOOKUP, 32'h8010_0ABC, 32'h0, 1'b0, 3'd5));
   endtask

   task automatic test_flush_and_nop();
      send_request(make_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7));
      send_request(make_req(OP_LOOKUP, 32'h1234_5001, 32'h0, 1'b0, 3'd3));
      send_request(make_req(OP_FLUSH, 32'h1234_5001, 32'h0, 1'b0, 3'd3));
      send_request(make_req(OP_LOOKUP, 32'h1234_5001, 32'h0, 1'b0, 3'd3));
      send_request(make_req(OP_REFILL, 32'h1234_5000, 32'h0000_1000, 1'b0, 3'd3));
      send_request(make_req(OP_LOOKUP, 32'h1234_5001, 32'h0, 1'b0, 3'd3));
      send_request(make_req(OP_LOOKUP, 32'h8012_3456, 32'h0, 1'b0, 3'd5));
   endtask

   task automatic test_random_traffic(int count, int idle_pct);
      req_type r;
      mapping_type m;
      int pick;
      int n;
      sender_idle_pct = idle_pct;
      for (n = 0; n < count; n++) begin
         r = make_req(OP_LOOKUP, $urandom(), $urandom(), 1'($urandom_range(1)),
                      3'($urandom_range(7)));
         pick = $urandom_range(99);
         if (pick < 45 && mapping_history.size() != 0) begin
            m = mapping_history[$urandom_range(mapping_history.size() - 1)];
            r.vaddr = m.vaddr;
            if (m.level) begin
               r.vaddr[SUPER_BITS-1:0] = SUPER_BITS'($urandom());
            end else begin
               r.vaddr[PAGE_BITS-1:0] = PAGE_BITS'($urandom());
            end
            if ($urandom_range(9) != 0) begin
               r.access_kind = m.kind;
            end
            if ($urandom_range(9) == 0) begin
               r.vaddr[$urandom_range(31, PAGE_BITS)] ^= 1'b1;
            end
         end else if (pick < 55) begin
            r.opcode = OP_LOOKUP;
         end else if (pick < 93) begin
            r.opcode = OP_REFILL;
            if ($urandom_range(4) == 0 && mapping_history.size() != 0) begin
               m = mapping_history[$urandom_range(mapping_history.size() - 1)];
               r.vaddr = m.vaddr;
               r.access_kind = m.kind;
            end
         end else if (pick < 95) begin
            r.opcode = OP_FLUSH;
         end else begin
            r.opcode = OP_NOP;
         end
         send_request(r);
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      sender_idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 6;
      test_basic_hits();
      test_overlap_order();
      test_flush_and_nop();
      test_random_traffic(360, 6);
      test_random_traffic(360, 57);
      test_random_traffic(360, 0);

      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("fifo_tlb_with_superpages_tb passed");
      end else begin
         $display("fifo_tlb_with_superpages_tb failed");
      end
      $finish;
   end

endmodule
